// ----- sv/lbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbt_pkg;

  // Window depth and price width
  localparam int WINDOW_MAX = 16;
  localparam int PRICE_BITS = 32;

  // Count wide enough to hold WINDOW_MAX itself
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  // Break register
  localparam int BREAK_W = 5;
  localparam logic [BREAK_W-1:0] BREAK_BARS_RESET = BREAK_W'(3);

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [CNT_W-1:0]      count_t;

  // Verdict of one window cell on the incoming close
  typedef struct packed {
    logic beyond_up;   // close above both stored prices, or cell not in use
    logic beyond_dn;   // close below both stored prices, or cell not in use
  } cell_verdict_t;

endpackage : lbt_pkg

`default_nettype wire

// ----- sv/lbt_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input bar channel
interface lbt_in_if;
  logic           valid;
  logic           ready;
  lbt_pkg::price_t bar_open;
  logic [lbt_pkg::PRICE_BITS-1:0] bar_close;

  modport source (output valid, output bar_open, output bar_close, input ready);
  modport sink   (input valid, input bar_open, input bar_close, output ready);
endinterface : lbt_in_if

// Result channel
interface lbt_out_if;
  logic            valid;
  logic            ready;
  logic            trend_up;
  lbt_pkg::price_t brick_high;
  lbt_pkg::price_t brick_low;
  logic            new_brick;
  logic            reversed;

  modport source (output valid, output trend_up, output brick_high, output brick_low,
                  output new_brick, output reversed, input ready);
  modport sink   (input valid, input trend_up, input brick_high, input brick_low,
                  input new_brick, input reversed, output ready);
endinterface : lbt_out_if

// Configuration write channel
interface lbt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lbt_pkg::BREAK_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : lbt_cfg_if

`default_nettype wire

// ----- sv/lbt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbt_cell (
  input  wire logic                   clk,
  input  wire logic                   shift_en,
  input  wire lbt_pkg::price_t        prev_open,
  input  wire lbt_pkg::price_t        prev_close,
  input  wire lbt_pkg::price_t        probe_close,
  input  wire logic                   in_use,
  output lbt_pkg::price_t             held_open,
  output lbt_pkg::price_t             held_close,
  output lbt_pkg::cell_verdict_t      verdict
);

  lbt_pkg::price_t open_r;
  lbt_pkg::price_t close_r;

  // Take the neighbour's bar on every accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      open_r  <= prev_open;
      close_r <= prev_close;
    end
  end

  // Compare the incoming close against this cell's bar
  always_comb begin
    verdict.beyond_up = !in_use || ((probe_close > open_r) && (probe_close > close_r));
    verdict.beyond_dn = !in_use || ((probe_close < open_r) && (probe_close < close_r));
  end

  assign held_open  = open_r;
  assign held_close = close_r;

endmodule : lbt_cell

`default_nettype wire

// ----- sv/line_break_trend_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line-break trend tracker. One closed bar (open, close) is taken per beat and
// one result beat follows for every bar, in the cycle after acceptance, from an
// output register; a new bar is taken in every cycle while the result side
// keeps up, so the sustained rate is one bar per cycle. The recent bars sit in
// a chain of WINDOW_MAX cells that shift by one place per accepted bar, and
// every cell compares the incoming close against its own bar in that same
// cycle, so the reversal check is combinational and adds no register. The window needs no
// clearing pass: a count of stored bars keeps unwritten cells out of the check.
// break_bars of zero acts as one and values above the window depth act as
// the window depth; write it only while no result is outstanding.
module line_break_trend_tracker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lbt_in_if.sink      in_bar,
  lbt_out_if.source   out_brick,
  lbt_cfg_if.sink     cfg_wr
);

  localparam int W = lbt_pkg::WINDOW_MAX;

  logic [lbt_pkg::BREAK_W-1:0] break_bars_r;
  lbt_pkg::count_t             bars_seen_r;
  lbt_pkg::count_t             bars_seen_nxt;
  logic                        trend_r;
  logic                        trend_nxt;
  lbt_pkg::price_t             upper_r;
  lbt_pkg::price_t             upper_nxt;
  lbt_pkg::price_t             lower_r;
  lbt_pkg::price_t             lower_nxt;
  logic                        made;
  logic                        rev;
  logic                        out_valid_r;
  logic                        take;

  lbt_pkg::count_t             n_eff;
  logic                        enough;
  logic                        all_up;
  logic                        all_dn;

  lbt_pkg::price_t             chain_open  [W+1];
  lbt_pkg::price_t             chain_close [W+1];
  lbt_pkg::cell_verdict_t      verdicts    [W];

  assign in_bar.ready = !out_valid_r || out_brick.ready;
  assign take         = in_bar.valid && in_bar.ready;
  assign cfg_wr.ready = 1'b1;

  // Hold the break register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_bars_r <= lbt_pkg::BREAK_BARS_RESET;
    end else if (cfg_wr.valid) begin
      break_bars_r <= cfg_wr.data;
    end
  end

  // Clamp the break count into one to the window depth
  always_comb begin
    if (break_bars_r == '0) begin
      n_eff = lbt_pkg::CNT_W'(1);
    end else if (lbt_pkg::CNT_W'(break_bars_r) > lbt_pkg::CNT_W'(W)) begin
      n_eff = lbt_pkg::CNT_W'(W);
    end else begin
      n_eff = lbt_pkg::CNT_W'(break_bars_r);
    end
  end

  // Chain of window cells, newest bar at the head
  assign chain_open[0]  = in_bar.bar_open;
  assign chain_close[0] = in_bar.bar_close;

  for (genvar k = 0; k < W; k++) begin : g_cell
    lbt_cell u_cell (
      .clk         (clk),
      .shift_en    (take),
      .prev_open   (chain_open[k]),
      .prev_close  (chain_close[k]),
      .probe_close (in_bar.bar_close),
      .in_use      (lbt_pkg::CNT_W'(k + 1) <= n_eff),
      .held_open   (chain_open[k+1]),
      .held_close  (chain_close[k+1]),
      .verdict     (verdicts[k])
    );
  end

  // Combine the cell verdicts
  always_comb begin
    all_up = 1'b1;
    all_dn = 1'b1;
    for (int k = 0; k < W; k++) begin
      all_up = all_up & verdicts[k].beyond_up;
      all_dn = all_dn & verdicts[k].beyond_dn;
    end
  end

  assign enough = (bars_seen_r >= n_eff);

  // Decide extension or reversal for the incoming bar
  always_comb begin
    trend_nxt = trend_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    made      = 1'b0;
    rev       = 1'b0;
    if (trend_r) begin
      if (in_bar.bar_close > upper_r) begin
        lower_nxt = upper_r;
        upper_nxt = in_bar.bar_close;
        made      = 1'b1;
      end else if ((in_bar.bar_close < lower_r) && enough && all_dn) begin
        trend_nxt = 1'b0;
        upper_nxt = lower_r;
        lower_nxt = in_bar.bar_close;
        made      = 1'b1;
        rev       = 1'b1;
      end
    end else begin
      if (in_bar.bar_close < lower_r) begin
        upper_nxt = lower_r;
        lower_nxt = in_bar.bar_close;
        made      = 1'b1;
      end else if ((in_bar.bar_close > upper_r) && enough && all_up) begin
        trend_nxt = 1'b1;
        lower_nxt = upper_r;
        upper_nxt = in_bar.bar_close;
        made      = 1'b1;
        rev       = 1'b1;
      end
    end
    bars_seen_nxt = (bars_seen_r < lbt_pkg::CNT_W'(W)) ? bars_seen_r + 1'b1 : bars_seen_r;
  end

  // Advance the brick state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trend_r     <= 1'b0;
      upper_r     <= '0;
      lower_r     <= '0;
      bars_seen_r <= '0;
    end else if (take) begin
      trend_r     <= trend_nxt;
      upper_r     <= upper_nxt;
      lower_r     <= lower_nxt;
      bars_seen_r <= bars_seen_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_brick.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_brick.trend_up   <= trend_nxt;
      out_brick.brick_high <= upper_nxt;
      out_brick.brick_low  <= lower_nxt;
      out_brick.new_brick  <= made;
      out_brick.reversed   <= rev;
    end
  end

  assign out_brick.valid = out_valid_r;

endmodule : line_break_trend_tracker

`default_nettype wire
